// ===== design/rtcm_pkg.sv =====
// Shared types and constants for the RGB to CMYK converter.
`timescale 1ns / 1ps
`default_nettype none
package rtcm_pkg;

  localparam int CH_NUM = 3;
  localparam int PIX_W  = 8;
  localparam int NUM_W  = 2 * PIX_W;
  localparam int STEPS  = PIX_W;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd200;
  localparam logic [PIX_W-1:0] PIX_MAX         = 8'd255;

  // One item as it travels along the divider row.
  typedef struct packed {
    logic [CH_NUM-1:0][NUM_W-1:0] rem;
    logic [CH_NUM-1:0][PIX_W-1:0] quo;
    logic [PIX_W-1:0]             den;
    logic [PIX_W-1:0]             k;
    logic                         blk;
  } cell_data_t;

endpackage
`default_nettype wire

// ===== design/rgb_to_cmyk_with_yellow_mask.sv =====
// RGB to CMYK converter with yellow mask: top level with divider row and output register.
// Pipeline: an accepted item passes the front stage, eight divider cells and the
// output register. Throughput: one item per cycle while m_axis_tready does not stall
// the row; each divider cell resolves one quotient bit.
// Reset: rst synchronous, clears all stage valid bits and sets the threshold to 200.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_cmyk_with_yellow_mask
  import rtcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,   // yellow_threshold
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // first_byte, second_byte, third_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // cyan, magenta, yellow, black
  output logic [0:0]       m_axis_tuser   // yellow_mask
);

  logic [PIX_W-1:0] yellow_threshold;
  cell_data_t       stage_data  [0:STEPS];
  logic             stage_valid [0:STEPS];
  logic             stage_ready [0:STEPS];
  logic             out_ready;
  cell_data_t       last;

  always_ff @(posedge clk) begin
    if (rst) begin
      yellow_threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      yellow_threshold <= cfg_wr_data;
    end
  end

  rtcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_data  (stage_data[0])
  );

  for (genvar j = 0; j < STEPS; j++) begin : g_cell
    rtcm_cell #(
      .STEP (STEPS - 1 - j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[j]),
      .in_ready  (stage_ready[j]),
      .in_data   (stage_data[j]),
      .out_valid (stage_valid[j+1]),
      .out_ready (stage_ready[j+1]),
      .out_data  (stage_data[j+1])
    );
  end

  assign last      = stage_data[STEPS];
  assign out_ready = !m_axis_tvalid || m_axis_tready;
  assign stage_ready[STEPS] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= stage_valid[STEPS];
    end
  end

  // Pure black forces cyan, magenta, yellow and the mask to zero, and black to 255.
  always_ff @(posedge clk) begin
    if (out_ready && stage_valid[STEPS]) begin
      if (last.blk) begin
        m_axis_tdata <= {PIX_MAX, {(CH_NUM*PIX_W){1'b0}}};
        m_axis_tuser <= 1'b0;
      end else begin
        m_axis_tdata <= {last.k, last.quo[2], last.quo[1], last.quo[0]};
        m_axis_tuser <= (last.quo[2] > yellow_threshold);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/rtcm_front.sv =====
// Front stage: invert channels, find black, form numerators and divisor.
`timescale 1ns / 1ps
`default_nettype none
module rtcm_front
  import rtcm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [CH_NUM*PIX_W-1:0] in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output cell_data_t                   out_data
);

  logic [CH_NUM-1:0][PIX_W-1:0] inv;
  logic [PIX_W-1:0]             kmin;
  cell_data_t                   data_next;

  always_comb begin
    for (int i = 0; i < CH_NUM; i++) begin
      inv[i] = ~in_data[i*PIX_W +: PIX_W];
    end
    kmin = (inv[0] < inv[1]) ? inv[0] : inv[1];
    if (inv[2] < kmin) begin
      kmin = inv[2];
    end
    data_next = '0;
    for (int i = 0; i < CH_NUM; i++) begin
      // (v - k) * 255 as (d << 8) - d
      data_next.rem[i] = {inv[i] - kmin, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, inv[i] - kmin};
    end
    data_next.den = ~kmin;
    data_next.k   = kmin;
    data_next.blk = (kmin == PIX_MAX);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/rtcm_cell.sv =====
// Divider cell: one restoring quotient bit for all three channels.
`timescale 1ns / 1ps
`default_nettype none
module rtcm_cell
  import rtcm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cell_data_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output cell_data_t out_data
);

  logic [NUM_W-1:0] den_shifted;
  cell_data_t       data_next;

  assign den_shifted = {{(NUM_W-PIX_W){1'b0}}, in_data.den} << STEP;

  always_comb begin
    data_next = in_data;
    for (int i = 0; i < CH_NUM; i++) begin
      if (in_data.rem[i] >= den_shifted) begin
        data_next.rem[i]       = in_data.rem[i] - den_shifted;
        data_next.quo[i][STEP] = 1'b1;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire
